@@ rtl/core/iir_pkg.sv @@
package iir_pkg;

  // default configuration
  localparam int ORDER_DEF     = 4;
  localparam int SAMPLE_W_DEF  = 24;
  localparam int COEF_FRAC_DEF = 28;

  // fixed widths
  localparam int DELAY_W = 56;
  localparam int COEF_W  = 32;
  localparam int YF_W    = 66;               // d0 + b0*x at any legal sample width
  localparam int PROD_W  = YF_W + COEF_W;    // coefficient times yf
  localparam int CFG_W   = 64;
  localparam int CFG_AW  = 3;
  localparam int BIT_CW  = 5;                // counts coefficient bits

  typedef enum logic [CFG_AW-1:0] {
    REG_NUM01 = 3'd0,
    REG_NUM23 = 3'd1,
    REG_NUM4  = 3'd2,
    REG_DEN12 = 3'd3,
    REG_DEN34 = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_YOUT
  } state_t;

  // which product the serial multiplier is forming
  typedef enum logic [1:0] {
    PH_B0,
    PH_BX,
    PH_AY
  } phase_t;

  function automatic logic signed [COEF_W-1:0] coef_b(input logic [3:0] k,
                                                      input logic [CFG_W-1:0] n01,
                                                      input logic [CFG_W-1:0] n23,
                                                      input logic [COEF_W-1:0] n4);
    case (k)
      4'd0:    coef_b = n01[31:0];
      4'd1:    coef_b = n01[63:32];
      4'd2:    coef_b = n23[31:0];
      4'd3:    coef_b = n23[63:32];
      4'd4:    coef_b = n4;
      default: coef_b = '0;
    endcase
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_a(input logic [3:0] k,
                                                      input logic [CFG_W-1:0] d12,
                                                      input logic [CFG_W-1:0] d34);
    case (k)
      4'd1:    coef_a = d12[31:0];
      4'd2:    coef_a = d12[63:32];
      4'd3:    coef_a = d34[31:0];
      4'd4:    coef_a = d34[63:32];
      default: coef_a = '0;
    endcase
  endfunction

endpackage

@@ rtl/core/iir_if.sv @@
interface iir_in_if #(parameter int W = 24);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_in;
  logic                block_last_in;
  modport source (output valid, sample_in, block_last_in, input ready);
  modport sink   (input valid, sample_in, block_last_in, output ready);
endinterface

interface iir_out_if #(parameter int W = 24);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_out;
  logic                block_last_out;
  modport source (output valid, sample_out, block_last_out, input ready);
  modport sink   (input valid, sample_out, block_last_out, output ready);
endinterface

@@ rtl/core/iir_df2_transposed_filter_top.sv @@
// The result becomes valid after the b0*x product and rounding, and later while the
// output register is still held by the previous result. A new sample is taken only
// once the previous one is finished: the bit-serial multiplier forms 2*ORDER+1
// products for each sample, one coefficient bit per cycle.
// Reset (rst_n low, synchronous): delays cleared, b0 = 1.0, other coefficients 0,
// output register empty.
module iir_df2_transposed_filter_top import iir_pkg::*; #(
  parameter int ORDER          = ORDER_DEF,
  parameter int SAMPLE_WIDTH   = SAMPLE_W_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  iir_in_if.sink            in_s,
  iir_out_if.source         out_s,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int JW = $clog2(ORDER + 1);
  localparam logic [BIT_CW-1:0] LAST_BIT = BIT_CW'(COEF_W - 1);
  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) <<< (COEF_FRAC_BITS - 1);

  state_t state_r, state_nxt;
  phase_t ph_r;
  logic [JW-1:0] j_r;
  logic signed [SAMPLE_WIDTH-1:0] x_r;
  logic last_r;
  logic signed [YF_W-1:0] yf_r, bx_r;
  logic signed [PROD_W-1:0] mc_r, pr_r;
  logic [COEF_W-1:0] mp_r;
  logic [BIT_CW-1:0] cnt_r;
  logic signed [DELAY_W-1:0] d_r [ORDER];
  logic [CFG_W-1:0] num01_r, num23_r, den12_r, den34_r;
  logic [COEF_W-1:0] num4_r;
  logic out_valid_r, out_last_r;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r;

  logic in_fire, out_fire, bit_last, out_free;
  logic signed [PROD_W-1:0] addend, pr_sum, fb, acc;
  logic signed [YF_W-1:0] yf_calc, ysh, ysat, smax, smin;
  logic [JW:0] d_sel;
  logic signed [DELAY_W-1:0] d_pick;
  logic fits;

  assign in_s.ready = (state_r == ST_IDLE);
  assign in_fire = in_s.valid && in_s.ready;
  assign out_fire = out_valid_r && out_s.ready;
  assign out_free = !out_valid_r || out_s.ready;
  assign bit_last = (cnt_r == LAST_BIT);

  assign out_s.valid = out_valid_r;
  assign out_s.sample_out = out_sample_r;
  assign out_s.block_last_out = out_last_r;

  // shift-add step; the sign bit of the coefficient carries negative weight
  assign addend = mp_r[0] ? (bit_last ? -mc_r : mc_r) : '0;
  assign pr_sum = pr_r + addend;

  // output: accumulator was preloaded with d0; round half up, saturate
  assign yf_calc = $signed(pr_sum[YF_W-1:0]);
  assign ysh  = (yf_r + (YF_W'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
  assign smax = YF_W'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
  assign smin = -smax - YF_W'(1);
  assign ysat = (ysh > smax) ? smax : ((ysh < smin) ? smin : ysh);

  // delay preload for the next b*x product: d1 after the output, else d(j+2)
  assign d_sel = (state_r == ST_YOUT) ? (JW+1)'(1) : (JW+1)'(j_r) + (JW+1)'(2);

  always_comb begin
    d_pick = '0;
    for (int i = 1; i < ORDER; i++) begin
      if (int'(d_sel) == i) d_pick = d_r[i];
    end
  end

  // delay update: bx_r holds d(j+1) + b*x, feedback was preloaded with the rounding half
  assign fb  = pr_sum >>> COEF_FRAC_BITS;
  assign acc = PROD_W'(bx_r) - fb;
  assign fits = (&acc[PROD_W-1:DELAY_W-1]) || !(|acc[PROD_W-1:DELAY_W-1]);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (bit_last) begin
          if (ph_r == PH_B0) state_nxt = ST_YOUT;
          else if (ph_r == PH_AY && 32'(j_r) == ORDER - 1) state_nxt = ST_IDLE;
        end
      end
      ST_YOUT: begin
        if (out_free) state_nxt = ST_MUL;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num01_r <= CFG_W'(1) << COEF_FRAC_BITS;
      num23_r <= '0;
      num4_r  <= '0;
      den12_r <= '0;
      den34_r <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_NUM01: num01_r <= cfg_data;
        REG_NUM23: num23_r <= cfg_data;
        REG_NUM4:  num4_r  <= cfg_data[COEF_W-1:0];
        REG_DEN12: den12_r <= cfg_data;
        REG_DEN34: den34_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_YOUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_YOUT && out_free) begin
      out_sample_r <= ysat[SAMPLE_WIDTH-1:0];
      out_last_r   <= last_r;
    end
  end

  // delay line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ORDER; i++) d_r[i] <= '0;
    end else if (state_r == ST_MUL && bit_last && ph_r == PH_AY) begin
      for (int i = 0; i < ORDER; i++) begin
        if (int'(j_r) == i) d_r[i] <= fits ? acc[DELAY_W-1:0] : '0;
      end
    end
  end

  // sequencer and serial multiplier
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= PH_B0;
      j_r   <= '0;
      cnt_r <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            x_r    <= in_s.sample_in;
            last_r <= in_s.block_last_in;
            mc_r   <= PROD_W'(in_s.sample_in);
            mp_r   <= coef_b(4'd0, num01_r, num23_r, num4_r);
            pr_r   <= PROD_W'(d_r[0]);
            cnt_r  <= '0;
            ph_r   <= PH_B0;
          end
        end
        ST_MUL: begin
          pr_r  <= pr_sum;
          mc_r  <= mc_r <<< 1;
          mp_r  <= mp_r >> 1;
          cnt_r <= cnt_r + BIT_CW'(1);
          if (bit_last) begin
            case (ph_r)
              PH_B0: begin
                yf_r <= yf_calc;
              end
              PH_BX: begin
                bx_r  <= $signed(pr_sum[YF_W-1:0]);
                mc_r  <= PROD_W'(yf_r);
                mp_r  <= coef_a(4'(j_r) + 4'd1, den12_r, den34_r);
                pr_r  <= RND_HALF;
                cnt_r <= '0;
                ph_r  <= PH_AY;
              end
              PH_AY: begin
                j_r   <= j_r + JW'(1);
                mc_r  <= PROD_W'(x_r);
                mp_r  <= coef_b(4'(j_r) + 4'd2, num01_r, num23_r, num4_r);
                pr_r  <= PROD_W'(d_pick);
                cnt_r <= '0;
                ph_r  <= PH_BX;
              end
              default: ph_r <= PH_B0;
            endcase
          end
        end
        ST_YOUT: begin
          if (out_free) begin
            j_r   <= '0;
            mc_r  <= PROD_W'(x_r);
            mp_r  <= coef_b(4'd1, num01_r, num23_r, num4_r);
            pr_r  <= PROD_W'(d_pick);
            cnt_r <= '0;
            ph_r  <= PH_BX;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/iir_chk.sv @@
module iir_chk #(parameter int W = 24) (
  input logic         clk,
  input logic         rst_n,
  input logic         in_valid,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic [W-1:0] out_sample,
  input logic         out_last
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_last))
    else $error("output dropped or changed while stalled");

  // one sample at a time: busy right after a transaction
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a sample is in work");

  // a new result appears only while a sample is still in work
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_ready)
    else $error("result appeared while idle");

  // reset empties the output register
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind iir_df2_transposed_filter_top iir_chk #(.W(SAMPLE_WIDTH)) u_iir_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_s.valid),
  .in_ready   (in_s.ready),
  .out_valid  (out_s.valid),
  .out_ready  (out_s.ready),
  .out_sample (out_s.sample_out),
  .out_last   (out_s.block_last_out)
);

@@ verif/testbench.sv @@
module testbench;
  import iir_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW = 24;
  localparam logic [CFG_AW-1:0] REG_UNUSED = 3'd7;
  localparam logic signed [127:0] HALF_LSB = 128'sd1 <<< (COEF_FRAC_DEF - 1);
  localparam logic signed [127:0] DELAY_MAX = (128'sd1 <<< (DELAY_W - 1)) - 1;
  localparam logic signed [127:0] DELAY_MIN = -(128'sd1 <<< (DELAY_W - 1));
  localparam logic signed [127:0] SAMP_MAX = 128'sd8388607;
  localparam logic signed [127:0] SAMP_MIN = -128'sd8388608;
  localparam logic [31:0] Q_ONE = 32'h1000_0000;

  typedef struct packed {
    logic [SW-1:0] sample;
    logic          last;
  } result_t;

  // directed row: either a register write or a sample, optionally with a known result
  typedef struct {
    bit                is_cfg;
    logic [CFG_AW-1:0] addr;
    logic [CFG_W-1:0]  data;
    logic [SW-1:0]     sample;
    logic              last;
    bit                known;
    logic [SW-1:0]     known_out;
  } row_t;

  logic clk;
  logic rst_n;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_W-1:0]  cfg_data;

  iir_in_if  #(.W(SW)) in_if ();
  iir_out_if #(.W(SW)) out_if ();

  iir_df2_transposed_filter_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_s    (in_if),
    .out_s   (out_if),
    .cfg_we  (cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  // shadow of the filter state
  logic [63:0] m_num01, m_num23, m_den12, m_den34;
  logic [31:0] m_num4;
  logic signed [DELAY_W-1:0] m_delay [4];

  result_t filtered_q[$];
  int  errors;
  bit  quiet;
  bit  long_hold_req;
  int  hold_cnt;
  row_t rows[$];

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("testbench: FAIL");
    $finish;
  end

  function automatic logic signed [31:0] num_coef(int k);
    case (k)
      0: return m_num01[31:0];
      1: return m_num01[63:32];
      2: return m_num23[31:0];
      3: return m_num23[63:32];
      4: return m_num4;
      default: return '0;
    endcase
  endfunction

  function automatic logic signed [31:0] den_coef(int k);
    case (k)
      1: return m_den12[31:0];
      2: return m_den12[63:32];
      3: return m_den34[31:0];
      4: return m_den34[63:32];
      default: return '0;
    endcase
  endfunction

  // one filter step: returns the rounded, saturated output and advances the delays
  function automatic logic [SW-1:0] filter_step(logic signed [SW-1:0] x);
    logic signed [127:0] yf, r, fb, acc, nxt, bk, ak, xw;
    logic signed [DELAY_W-1:0] old [4];
    for (int j = 0; j < 4; j++) old[j] = m_delay[j];
    xw = 128'(x);
    bk = 128'(num_coef(0));
    yf = 128'(old[0]) + bk * xw;
    r = (yf + HALF_LSB) >>> COEF_FRAC_DEF;
    if (r > SAMP_MAX) r = SAMP_MAX;
    if (r < SAMP_MIN) r = SAMP_MIN;
    for (int j = 0; j < 4; j++) begin
      nxt = (j < 3) ? 128'(old[j+1]) : 128'sd0;
      bk = 128'(num_coef(j + 1));
      ak = 128'(den_coef(j + 1));
      fb = (ak * yf + HALF_LSB) >>> COEF_FRAC_DEF;
      acc = nxt + bk * xw - fb;
      m_delay[j] = (acc > DELAY_MAX || acc < DELAY_MIN) ? '0 : acc[DELAY_W-1:0];
    end
    return r[SW-1:0];
  endfunction

  task automatic wait_idle();
    wait (filtered_q.size() == 0);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] a, logic [CFG_W-1:0] d);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_addr <= a;
    cfg_data <= d;
    @(posedge clk);
    cfg_we   <= 1'b0;
    case (a)
      REG_NUM01: m_num01 = d;
      REG_NUM23: m_num23 = d;
      REG_NUM4:  m_num4  = d[31:0];
      REG_DEN12: m_den12 = d;
      REG_DEN34: m_den34 = d;
      default: ;
    endcase
  endtask

  // offer one sample; prediction is queued when the transaction completes
  task automatic send_sample(logic [SW-1:0] s, logic l, bit known, logic [SW-1:0] kv);
    int gap;
    result_t e;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.sample_in     <= s;
    in_if.block_last_in <= l;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    e.sample = filter_step(s);
    e.last   = l;
    if (known) e.sample = kv;
    filtered_q.insert(filtered_q.size(), e);
  endtask

  function automatic logic [31:0] rand_coef(int mode);
    logic [31:0] c;
    case (mode)
      0: c = $urandom;
      1: c = $urandom_range(0, 32'h0800_0000);
      default: c = $urandom_range(0, 32'h0200_0000);
    endcase
    if (mode != 0 && $urandom_range(0, 1)) c = -c;
    return c;
  endfunction

  function automatic logic [SW-1:0] rand_sample();
    case ($urandom_range(0, 3))
      0: return SW'($urandom);
      1: return SW'($urandom_range(0, 255) - 128);
      2: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      default: return SW'($urandom_range(0, 24'h0FFFFF) - 24'h080000);
    endcase
  endfunction

  function automatic row_t cfg_row(logic [CFG_AW-1:0] a, logic [CFG_W-1:0] d);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1; r.addr = a; r.data = d;
    return r;
  endfunction

  function automatic row_t smp_row(logic [SW-1:0] s, logic l, bit k, logic [SW-1:0] kv);
    row_t r;
    r = '{default: '0};
    r.sample = s; r.last = l; r.known = k; r.known_out = kv;
    return r;
  endfunction

  function automatic void add_row(row_t r);
    rows.insert(rows.size(), r);
  endfunction

  // result receiver with random back-pressure and one long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_cnt <= 0;
    end else if (long_hold_req) begin
      long_hold_req <= 1'b0;
      hold_cnt <= 4000;
      out_if.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_if.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      hold_cnt <= $urandom_range(0, 9);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (filtered_q.size() == 0) begin
        $display("%0t: unexpected result sample=%h last=%b", $time,
                 out_if.sample_out, out_if.block_last_out);
        errors++;
      end else begin
        e = filtered_q.pop_front();
        if (out_if.sample_out !== e.sample) begin
          $display("%0t: sample_out expected %h actual %h", $time, e.sample,
                   out_if.sample_out);
          errors++;
        end
        if (out_if.block_last_out !== e.last) begin
          $display("%0t: block_last_out expected %b actual %b", $time, e.last,
                   out_if.block_last_out);
          errors++;
        end
      end
    end
  end

  initial begin
    int mode;
    bit second;
    errors = 0;
    quiet = 0;
    long_hold_req = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = REG_NUM01;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.sample_in = '0;
    in_if.block_last_in = 1'b0;
    m_num01 = 64'(Q_ONE);
    m_num23 = '0; m_num4 = '0; m_den12 = '0; m_den34 = '0;
    for (int j = 0; j < 4; j++) m_delay[j] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset coefficients pass samples through unchanged
    add_row(smp_row(24'h7FFFFF, 1, 1, 24'h7FFFFF));
    add_row(smp_row(24'h800000, 0, 1, 24'h800000));
    add_row(smp_row(24'h000000, 1, 1, 24'h000000));
    add_row(smp_row(24'hFFFFFF, 0, 1, 24'hFFFFFF));
    add_row(smp_row(24'h000001, 0, 1, 24'h000001));
    // write to an unknown index changes nothing
    add_row(cfg_row(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF));
    add_row(smp_row(24'h123456, 1, 1, 24'h123456));
    // largest gain saturates the output
    add_row(cfg_row(REG_NUM01, 64'h0000_0000_7FFF_FFFF));
    add_row(smp_row(24'h7FFFFF, 0, 1, 24'h7FFFFF));
    add_row(smp_row(24'h800000, 0, 1, 24'h800000));
    add_row(smp_row(24'h000010, 1, 0, '0));
    // most negative gain with taps at the extremes, forcing delay overflow
    add_row(cfg_row(REG_NUM01, 64'h7FFF_FFFF_8000_0000));
    add_row(cfg_row(REG_NUM23, 64'h8000_0000_7FFF_FFFF));
    add_row(cfg_row(REG_NUM4,  64'hDEAD_BEEF_8000_0000));
    add_row(cfg_row(REG_DEN12, 64'h8000_0000_7FFF_FFFF));
    add_row(cfg_row(REG_DEN34, 64'h7FFF_FFFF_8000_0000));
    for (int i = 0; i < 8; i++)
      add_row(smp_row(i[0] ? 24'h7FFFFF : 24'h800000, i[1], 0, '0));

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        in_if.valid <= 1'b0;
        write_reg(rows[i].addr, rows[i].data);
      end else begin
        send_sample(rows[i].sample, rows[i].last, rows[i].known, rows[i].known_out);
      end
    end

    // random phases with changing coefficients
    for (int p = 0; p < 12; p++) begin
      in_if.valid <= 1'b0;
      mode = (p < 2) ? 0 : $urandom_range(1, 2);
      second = (p % 3 == 1);
      write_reg(REG_NUM01, {rand_coef(mode), (p == 5) ? Q_ONE : rand_coef(mode)});
      write_reg(REG_NUM23, {second ? 32'h0 : rand_coef(mode), rand_coef(mode)});
      write_reg(REG_NUM4,  {32'($urandom), second ? 32'h0 : rand_coef(mode)});
      write_reg(REG_DEN12, {rand_coef(mode), rand_coef(mode)});
      write_reg(REG_DEN34, second ? 64'h0 : {rand_coef(mode), rand_coef(mode)});
      if (p == 11) quiet = 1;
      for (int i = 0; i < 102; i++) begin
        if (p == 4 && i == 10) long_hold_req = 1;
        send_sample(rand_sample(), 1'($urandom), 0, '0);
      end
    end
    in_if.valid <= 1'b0;

    wait (filtered_q.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && filtered_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
